/* design/hrm_pkg.sv */
`timescale 1ns / 1ps

package hrm_pkg;

	// Pixel, divider, register bus and threshold widths
	localparam int PIX_W     = 8;
	localparam int NUM_W     = 17;  // widest numerator: 510*d + v
	localparam int DEN_W     = 9;   // 2*v or 2*d
	localparam int DIV_STEPS = 8;   // one quotient bit per stage
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int HUE_W     = 8;
	localparam int BND_W     = 9;

	// Which component holds the maximum, in red, green, blue priority
	localparam logic [1:0] SEC_RED   = 2'd0;
	localparam logic [1:0] SEC_GREEN = 2'd1;
	localparam logic [1:0] SEC_BLUE  = 2'd2;

	// Register indexes (byte address is four times the index)
	localparam logic [2:0] REG_MIN_HUE = 3'd0;
	localparam logic [2:0] REG_MAX_HUE = 3'd1;
	localparam logic [2:0] REG_MIN_SAT = 3'd2;
	localparam logic [2:0] REG_MAX_SAT = 3'd3;
	localparam logic [2:0] REG_MIN_VAL = 3'd4;
	localparam logic [2:0] REG_MAX_VAL = 3'd5;

	// Register reset values
	localparam logic [HUE_W-1:0] MIN_HUE_RST = 8'd0;
	localparam logic [HUE_W-1:0] MAX_HUE_RST = 8'd181;
	localparam logic [BND_W-1:0] MIN_SAT_RST = 9'd0;
	localparam logic [BND_W-1:0] MAX_SAT_RST = 9'd256;
	localparam logic [BND_W-1:0] MIN_VAL_RST = 9'd0;
	localparam logic [BND_W-1:0] MAX_VAL_RST = 9'd256;

	// Hue offsets: the divider returns 30 + the in-sector fraction, a value in 0..60
	localparam logic [HUE_W-1:0] HUE_MID      = 8'd30;
	localparam logic [HUE_W-1:0] HUE_RED_WRAP = 8'd150;
	localparam logic [HUE_W-1:0] HUE_GREEN_OF = 8'd30;
	localparam logic [HUE_W-1:0] HUE_BLUE_OF  = 8'd90;

endpackage

/* design/hsv_range_mask_top.sv */
`timescale 1ns / 1ps

// A pixel beat passes stage 1, stage 2, stage 3, the divider steps and stage 12 in order.
// Throughput: one pixel per clock while the output is not stalled; two eight-stage restoring
// dividers, one quotient bit per stage, make up eight of the 12 register stages.
// A stall on the output freezes every stage at once; nothing is lost or repeated.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the register defaults.
module hsv_range_mask_top (
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // blue[7:0], green[15:8], red[23:16]
	// stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // hue[7:0], saturation[15:8], brightness[23:16]
	output logic        m_tuser,   // in_range[0]
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PW = hrm_pkg::PIX_W;
	localparam int NW = hrm_pkg::NUM_W;
	localparam int DW = hrm_pkg::DEN_W;
	localparam int NS = hrm_pkg::DIV_STEPS;
	localparam int HW = hrm_pkg::HUE_W;
	localparam int BW = hrm_pkg::BND_W;

	// ---------------------------------------------------------------
	// Register file
	// ---------------------------------------------------------------
	logic [HW-1:0] min_hue_q, max_hue_q;
	logic [BW-1:0] min_sat_q, max_sat_q, min_val_q, max_val_q;
	logic          wr_en;
	logic [2:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	// Write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hue_q <= hrm_pkg::MIN_HUE_RST;
			max_hue_q <= hrm_pkg::MAX_HUE_RST;
			min_sat_q <= hrm_pkg::MIN_SAT_RST;
			max_sat_q <= hrm_pkg::MAX_SAT_RST;
			min_val_q <= hrm_pkg::MIN_VAL_RST;
			max_val_q <= hrm_pkg::MAX_VAL_RST;
		end else if (wr_en) begin
			case (reg_idx)
				hrm_pkg::REG_MIN_HUE: min_hue_q <= pwdata[HW-1:0];
				hrm_pkg::REG_MAX_HUE: max_hue_q <= pwdata[HW-1:0];
				hrm_pkg::REG_MIN_SAT: min_sat_q <= pwdata[BW-1:0];
				hrm_pkg::REG_MAX_SAT: max_sat_q <= pwdata[BW-1:0];
				hrm_pkg::REG_MIN_VAL: min_val_q <= pwdata[BW-1:0];
				hrm_pkg::REG_MAX_VAL: max_val_q <= pwdata[BW-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			hrm_pkg::REG_MIN_HUE: prdata = {24'd0, min_hue_q};
			hrm_pkg::REG_MAX_HUE: prdata = {24'd0, max_hue_q};
			hrm_pkg::REG_MIN_SAT: prdata = {23'd0, min_sat_q};
			hrm_pkg::REG_MAX_SAT: prdata = {23'd0, max_sat_q};
			hrm_pkg::REG_MIN_VAL: prdata = {23'd0, min_val_q};
			hrm_pkg::REG_MAX_VAL: prdata = {23'd0, max_val_q};
			default:              prdata = 32'd0;
		endcase
	end

	// ---------------------------------------------------------------
	// Pipeline control: all stages advance together
	// ---------------------------------------------------------------
	logic adv;
	logic vld_s1, vld_s2, vld_s12;

	assign adv      = !vld_s12 || m_tready;
	assign s_tready = adv;

	// ---------------------------------------------------------------
	// Stage 1: max, min and the sector operands
	// ---------------------------------------------------------------
	logic [PW-1:0] px_b, px_g, px_r;
	logic [PW-1:0] max_c, min_c, op_a, op_c;
	logic [1:0]    sec_c;
	logic [PW-1:0] v_s1, mn_s1, pa_s1, pc_s1;
	logic [1:0]    sec_s1;

	assign px_b = s_tdata[7:0];
	assign px_g = s_tdata[15:8];
	assign px_r = s_tdata[23:16];

	// Pick the sector of the maximum; u = a - c + d in the next stage
	always_comb begin
		if (px_r >= px_g && px_r >= px_b) begin
			sec_c = hrm_pkg::SEC_RED;
			max_c = px_r;
			op_a  = px_g;
			op_c  = px_b;
		end else if (px_g >= px_b) begin
			sec_c = hrm_pkg::SEC_GREEN;
			max_c = px_g;
			op_a  = px_b;
			op_c  = px_r;
		end else begin
			sec_c = hrm_pkg::SEC_BLUE;
			max_c = px_b;
			op_a  = px_r;
			op_c  = px_g;
		end
		min_c = px_r;
		if (px_g < min_c) min_c = px_g;
		if (px_b < min_c) min_c = px_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1   <= max_c;
			mn_s1  <= min_c;
			pa_s1  <= op_a;
			pc_s1  <= op_c;
			sec_s1 <= sec_c;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: chroma d and the biased hue difference u in 0..2d
	// ---------------------------------------------------------------
	logic [PW-1:0] d_c;
	logic [9:0]    u_c;
	logic [PW-1:0] v_s2, d_s2;
	logic [8:0]    u_s2;
	logic [1:0]    sec_s2;

	assign d_c = v_s1 - mn_s1;
	assign u_c = {2'b00, pa_s1} + {2'b00, d_c} - {2'b00, pc_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s2   <= v_s1;
			d_s2   <= d_c;
			u_s2   <= u_c[8:0];
			sec_s2 <= sec_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3 and divider: index 0 is stage 3, index k is divider step k
	// ---------------------------------------------------------------
	logic          vld_s  [0:NS];
	logic [NW-1:0] sat_rem_s [0:NS];
	logic [NW-1:0] hue_rem_s [0:NS];
	logic [DW-1:0] sat_den_s [0:NS];
	logic [DW-1:0] hue_den_s [0:NS];
	logic [NS-1:0] sat_quo_s [0:NS];
	logic [NS-1:0] hue_quo_s [0:NS];
	logic [PW-1:0] val_s  [0:NS];
	logic [1:0]    sec_s  [0:NS];
	logic          zd_s   [0:NS];

	logic [NW-1:0] sat_num_c, hue_num_c;

	// 510*d + v and 60*u + d by shift and add
	assign sat_num_c = (NW'(d_s2) << 9) - (NW'(d_s2) << 1) + NW'(v_s2);
	assign hue_num_c = (NW'(u_s2) << 6) - (NW'(u_s2) << 2) + NW'(d_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_rem_s[0] <= sat_num_c;
			hue_rem_s[0] <= hue_num_c;
			sat_den_s[0] <= {v_s2, 1'b0};
			hue_den_s[0] <= {d_s2, 1'b0};
			sat_quo_s[0] <= '0;
			hue_quo_s[0] <= '0;
			val_s[0]     <= v_s2;
			sec_s[0]     <= sec_s2;
			zd_s[0]      <= (d_s2 == '0);
		end
	end

	// Restoring division, most significant quotient bit first
	for (genvar k = 1; k <= NS; k++) begin : g_div
		localparam int SH = NS - k;
		logic [NW-1:0] sat_trial, hue_trial;
		logic          sat_ge, hue_ge;

		assign sat_trial = NW'(sat_den_s[k-1]) << SH;
		assign hue_trial = NW'(hue_den_s[k-1]) << SH;
		assign sat_ge    = sat_rem_s[k-1] >= sat_trial;
		assign hue_ge    = hue_rem_s[k-1] >= hue_trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sat_rem_s[k] <= sat_ge ? sat_rem_s[k-1] - sat_trial : sat_rem_s[k-1];
				hue_rem_s[k] <= hue_ge ? hue_rem_s[k-1] - hue_trial : hue_rem_s[k-1];
				sat_quo_s[k] <= {sat_quo_s[k-1][NS-2:0], sat_ge};
				hue_quo_s[k] <= {hue_quo_s[k-1][NS-2:0], hue_ge};
				sat_den_s[k] <= sat_den_s[k-1];
				hue_den_s[k] <= hue_den_s[k-1];
				val_s[k]     <= val_s[k-1];
				sec_s[k]     <= sec_s[k-1];
				zd_s[k]      <= zd_s[k-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 12: place hue in its sector, apply the range tests
	// ---------------------------------------------------------------
	logic [HW-1:0] quo_h, hue_c, sat_c;
	logic          hue_ok, sat_ok, val_ok;
	logic [HW-1:0] hue_s12, sat_s12, val_s12;
	logic          pass_s12;

	assign quo_h = hue_quo_s[NS];

	always_comb begin
		case (sec_s[NS])
			hrm_pkg::SEC_RED: begin
				if (quo_h < hrm_pkg::HUE_MID) hue_c = quo_h + hrm_pkg::HUE_RED_WRAP;
				else                          hue_c = quo_h - hrm_pkg::HUE_MID;
			end
			hrm_pkg::SEC_GREEN: hue_c = quo_h + hrm_pkg::HUE_GREEN_OF;
			hrm_pkg::SEC_BLUE:  hue_c = quo_h + hrm_pkg::HUE_BLUE_OF;
			default:            hue_c = quo_h;
		endcase
		// Gray pixel: no hue and no saturation
		if (zd_s[NS]) begin
			hue_c = '0;
			sat_c = '0;
		end else begin
			sat_c = sat_quo_s[NS];
		end
	end

	always_comb begin
		if (min_hue_q <= max_hue_q) hue_ok = hue_c >= min_hue_q && hue_c <= max_hue_q;
		else                        hue_ok = hue_c < max_hue_q || hue_c > min_hue_q;
		sat_ok = {1'b0, sat_c} >= min_sat_q && {1'b0, sat_c} <= max_sat_q;
		val_ok = {1'b0, val_s[NS]} >= min_val_q && {1'b0, val_s[NS]} <= max_val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else if (adv) begin
			vld_s12 <= vld_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_s12  <= hue_c;
			sat_s12  <= sat_c;
			val_s12  <= val_s[NS];
			pass_s12 <= hue_ok && sat_ok && val_ok;
		end
	end

	assign m_tvalid = vld_s12;
	assign m_tdata  = {val_s12, sat_s12, hue_s12};
	assign m_tuser  = pass_s12;

endmodule

/* design/hrm_checker.sv */
`timescale 1ns / 1ps

module hrm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// Hue stays in its 180-step circle
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] <= 8'd179))
		else $error("hue out of range");

	// Zero saturation means a gray pixel, which has zero hue
	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[15:8] == 8'd0) |-> (m_tdata[7:0] == 8'd0))
		else $error("gray pixel with nonzero hue");

	// Black pixel has zero saturation
	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[23:16] == 8'd0) |-> (m_tdata[15:8] == 8'd0))
		else $error("black pixel with nonzero saturation");

	// A stalled output also stalls the input
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while output stalled");

	// A stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled output beat changed");

endmodule

bind hsv_range_mask_top hrm_checker u_hrm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* tb/hsv_range_mask_top_test.sv */
`timescale 1ns / 1ps

module hsv_range_mask_top_test;

	// One converted pixel as it leaves the block
	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] sat;
		logic [7:0] bright;
		logic       in_range;
	} hsv_pix_t;

	// Directed pixel; the result is typed in only where known is set
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       known;
		hsv_pix_t   res;
	} pix_row_t;

	localparam int N_DIR      = 17;
	localparam int N_PHASES   = 12;
	localparam int PHASE_PIX  = 103;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // blue[7:0], green[15:8], red[23:16]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // hue[7:0], saturation[15:8], brightness[23:16]
	logic        m_tuser;        // in_range[0]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Mirror of the threshold registers
	logic [7:0] cfg_min_hue = hrm_pkg::MIN_HUE_RST;
	logic [7:0] cfg_max_hue = hrm_pkg::MAX_HUE_RST;
	logic [8:0] cfg_min_sat = hrm_pkg::MIN_SAT_RST;
	logic [8:0] cfg_max_sat = hrm_pkg::MAX_SAT_RST;
	logic [8:0] cfg_min_val = hrm_pkg::MIN_VAL_RST;
	logic [8:0] cfg_max_val = hrm_pkg::MAX_VAL_RST;

	hsv_pix_t hsv_pending [$];
	hsv_pix_t want;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       hold_left = 0;
	int       err_count = 0;
	int       n_sent = 0;
	int       n_checked = 0;
	int       n_masked = 0;
	int       n_settings = 0;

	// blue, green, red, known, hue, saturation, brightness, in_range
	pix_row_t dir_rows [N_DIR] = '{
		{8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0,   1'b1},  // black
		{8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255, 1'b1},  // white
		{8'd0,   8'd0,   8'd255, 1'b1, 8'd0,   8'd255, 8'd255, 1'b1},  // red
		{8'd0,   8'd255, 8'd0,   1'b1, 8'd60,  8'd255, 8'd255, 1'b1},  // green
		{8'd255, 8'd0,   8'd0,   1'b1, 8'd120, 8'd255, 8'd255, 1'b1},  // blue
		{8'd0,   8'd255, 8'd255, 1'b1, 8'd30,  8'd255, 8'd255, 1'b1},  // yellow
		{8'd255, 8'd255, 8'd0,   1'b1, 8'd90,  8'd255, 8'd255, 1'b1},  // cyan
		{8'd255, 8'd0,   8'd255, 1'b1, 8'd150, 8'd255, 8'd255, 1'b1},  // magenta
		{8'd5,   8'd0,   8'd255, 1'b0, 25'd0},  // negative hue wraps to 179
		{8'd3,   8'd0,   8'd255, 1'b0, 25'd0},  // small negative rounds to zero
		{8'd41,  8'd40,  8'd100, 1'b0, 25'd0},  // negative hue half step rounds up
		{8'd1,   8'd1,   8'd2,   1'b0, 25'd0},  // saturation half step
		{8'd0,   8'd0,   8'd1,   1'b0, 25'd0},  // darkest non-black
		{8'd10,  8'd200, 8'd200, 1'b0, 25'd0},  // red and green share the max
		{8'd200, 8'd200, 8'd10,  1'b0, 25'd0},  // green and blue share the max
		{8'd128, 8'd128, 8'd128, 1'b0, 25'd0},  // mid gray
		{8'd170, 8'd85,  8'd204, 1'b0, 25'd0}   // alternating bits in blue and green, bit pairs in red
	};

	hsv_range_mask_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// Round toward minus infinity for a positive divisor
	function automatic int floor_quot(int num, int den);
		int q;
		q = num / den;
		if (num % den != 0 && num < 0) begin
			q -= 1;
		end
		return q;
	endfunction

	// Convert one pixel and apply the current thresholds
	function automatic hsv_pix_t hsv_convert(logic [7:0] b, logic [7:0] g, logic [7:0] r);
		int       bi, gi, ri, v, mn, d, s, h, hue;
		bit       hue_ok;
		hsv_pix_t px;
		bi = b;
		gi = g;
		ri = r;
		v = ri;
		if (gi > v) v = gi;
		if (bi > v) v = bi;
		mn = ri;
		if (gi < mn) mn = gi;
		if (bi < mn) mn = bi;
		d = v - mn;
		s = (v == 0) ? 0 : floor_quot(510 * d + v, 2 * v);
		if (d == 0) begin
			hue = 0;
		end else begin
			if (v == ri) h = gi - bi;
			else if (v == gi) h = bi - ri + 2 * d;
			else h = ri - gi + 4 * d;
			hue = floor_quot(60 * h + d, 2 * d);
			if (hue < 0) hue += 180;
		end
		if (cfg_min_hue <= cfg_max_hue) begin
			hue_ok = hue >= cfg_min_hue && hue <= cfg_max_hue;
		end else begin
			hue_ok = hue < cfg_max_hue || hue > cfg_min_hue;
		end
		px.hue      = hue[7:0];
		px.sat      = s[7:0];
		px.bright   = v[7:0];
		px.in_range = hue_ok && s >= cfg_min_sat && s <= cfg_max_sat &&
			v >= cfg_min_val && v <= cfg_max_val;
		return px;
	endfunction

	// Mix of uniform, gray, two-equal, saturated, dark and near-gray pixels; returns {r, g, b}
	function automatic logic [23:0] rand_pixel();
		logic [7:0] b, g, r;
		int         pick;
		pick = $urandom_range(0, 9);
		b = 8'($urandom);
		g = 8'($urandom);
		r = 8'($urandom);
		case (pick)
			0: begin
				g = b;
				r = b;
			end
			1: begin
				if ($urandom_range(0, 1)) g = r;
				else g = b;
			end
			2: begin
				b = {8{1'($urandom_range(0, 1))}};
				g = {8{1'($urandom_range(0, 1))}};
				r = {8{1'($urandom_range(0, 1))}};
			end
			3: begin
				b = 8'($urandom_range(0, 3));
				g = 8'($urandom_range(0, 3));
				r = 8'($urandom_range(0, 3));
			end
			4: begin
				g = b + 8'($urandom_range(0, 2));
				r = b + 8'($urandom_range(0, 2));
			end
			default: ;
		endcase
		return {r, g, b};
	endfunction

	// Offer one pixel beat and queue its expected result once taken
	task automatic send_pixel(input logic [23:0] pix, input bit known, input hsv_pix_t fixed);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		hsv_pending.insert(hsv_pending.size(),
			known ? fixed : hsv_convert(pix[7:0], pix[15:8], pix[23:16]));
		n_sent++;
		@(negedge clk);
	endtask

	// Register write with a setup phase, then an access phase; call at a falling edge
	task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			hrm_pkg::REG_MIN_HUE: cfg_min_hue = val[7:0];
			hrm_pkg::REG_MAX_HUE: cfg_max_hue = val[7:0];
			hrm_pkg::REG_MIN_SAT: cfg_min_sat = val;
			hrm_pkg::REG_MAX_SAT: cfg_max_sat = val;
			hrm_pkg::REG_MIN_VAL: cfg_min_val = val;
			hrm_pkg::REG_MAX_VAL: cfg_max_val = val;
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// Leave the bus idle before the next access
		@(negedge clk);
	endtask

	task automatic set_thresholds(input logic [8:0] hlo, input logic [8:0] hhi,
		input logic [8:0] slo, input logic [8:0] shi, input logic [8:0] vlo,
		input logic [8:0] vhi);
		write_reg(hrm_pkg::REG_MIN_HUE, hlo);
		write_reg(hrm_pkg::REG_MAX_HUE, hhi);
		write_reg(hrm_pkg::REG_MIN_SAT, slo);
		write_reg(hrm_pkg::REG_MAX_SAT, shi);
		write_reg(hrm_pkg::REG_MIN_VAL, vlo);
		write_reg(hrm_pkg::REG_MAX_VAL, vhi);
		n_settings++;
	endtask

	// Hold until every queued result has come back
	task automatic drain();
		while (hsv_pending.size() != 0) @(negedge clk);
	endtask

	// Drive output ready; a pending hold-off overrides random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Check each result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (hsv_pending.size() == 0) begin
				$error("result beat with no pixel pending: tdata %h tuser %b", m_tdata, m_tuser);
				err_count++;
			end else begin
				want = hsv_pending.pop_front();
				n_checked++;
				if (m_tuser) n_masked++;
				if (m_tdata[7:0] !== want.hue) begin
					$error("hue: expected %0d, got %0d", want.hue, m_tdata[7:0]);
					err_count++;
				end
				if (m_tdata[15:8] !== want.sat) begin
					$error("saturation: expected %0d, got %0d", want.sat, m_tdata[15:8]);
					err_count++;
				end
				if (m_tdata[23:16] !== want.bright) begin
					$error("brightness: expected %0d, got %0d", want.bright, m_tdata[23:16]);
					err_count++;
				end
				if (m_tuser !== want.in_range) begin
					$error("in_range: expected %0d, got %0d", want.in_range, m_tuser);
					err_count++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		#5ms;
		$display("hsv_range_mask_top_test: errors");
		$finish;
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pixels under the reset thresholds
		for (int i = 0; i < N_DIR; i++) begin
			send_pixel({dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue},
				dir_rows[i].known, dir_rows[i].res);
		end
		s_tvalid <= 1'b0;

		// Random pixels, one threshold setting and one idle pattern per phase
		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			send_idle_pct  = 0;
			recv_stall_pct = 0;
			case (ph)
				0: set_thresholds(9'd0, 9'd181, 9'd0, 9'd256, 9'd0, 9'd256);
				1: set_thresholds(9'd20, 9'd40, 9'd50, 9'd200, 9'd30, 9'd220);
				2: set_thresholds(9'd170, 9'd10, 9'd0, 9'd256, 9'd0, 9'd256);
				3: set_thresholds(9'd60, 9'd60, 9'd255, 9'd255, 9'd255, 9'd255);
				4: set_thresholds(9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
				5: set_thresholds(9'd255, 9'd255, 9'd511, 9'd511, 9'd511, 9'd511);
				6: set_thresholds(9'd0, 9'd181, 9'd256, 9'd0, 9'd0, 9'd256);
				7: set_thresholds(9'd181, 9'd0, 9'd0, 9'd256, 9'd0, 9'd256);
				default: set_thresholds(9'($urandom_range(0, 181)), 9'($urandom_range(0, 181)),
					9'($urandom_range(0, 256)), 9'($urandom_range(0, 256)),
					9'($urandom_range(0, 256)), 9'($urandom_range(0, 256)));
			endcase
			case (ph % 4)
				1: send_idle_pct = 63;
				2: recv_stall_pct = 63;
				3: begin
					send_idle_pct  = 13;
					recv_stall_pct = 13;
				end
				default: ;
			endcase
			// Back up the pipeline until the input stalls
			if (ph == 0) begin
				@(posedge clk);
				hold_left = HOLD_CYCLES;
				@(negedge clk);
			end
			for (int i = 0; i < PHASE_PIX; i++) begin
				send_pixel(rand_pixel(), 1'b0, '0);
			end
			s_tvalid <= 1'b0;
		end

		drain();
		repeat (20) @(posedge clk);
		if (hsv_pending.size() != 0) begin
			$error("%0d results never arrived", hsv_pending.size());
			err_count++;
		end
		$display("Converted %0d of %0d pixels under %0d threshold settings, %0d inside the mask.",
			n_checked, n_sent, n_settings, n_masked);
		if (err_count == 0) begin
			$display("hsv_range_mask_top_test: clean");
		end else begin
			$display("hsv_range_mask_top_test: errors");
		end
		$finish;
	end

endmodule
